FILE: design/nfa_ss_pkg.sv
// Shared types, constants and helpers of the NFA set-step block.
package nfa_ss_pkg;

    localparam int SET_W        = 16;
    localparam int ROW_W        = 4;
    localparam int SYM_W        = 8;
    localparam int STORE_AW     = 12;
    localparam int SYMBOL_COUNT = 129;

    localparam logic [SYM_W-1:0] EPS_SYMBOL = 8'd128;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [ROW_W-1:0] from_state;
        logic [SYM_W-1:0] symbol;
        logic [SET_W-1:0] target_set;
        logic [SET_W-1:0] state_set;
    } nfa_ss_in_t;

    typedef struct packed {
        logic [SET_W-1:0] next_set;
        logic             accepting;
    } nfa_ss_out_t;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [SET_W-1:0]    wdata;
        logic                re;
        logic [STORE_AW-1:0] raddr;
    } nfa_ss_store_req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOVE,
        ST_CLOSE,
        ST_DONE
    } nfa_ss_state_t;

    // Row-major address: state * 129 + symbol.
    function automatic logic [STORE_AW-1:0] store_addr(input logic [ROW_W-1:0] st,
                                                       input logic [SYM_W-1:0] sym);
        logic [STORE_AW-1:0] base;
        base = {1'b0, st, 7'b0};
        return base + STORE_AW'(st) + STORE_AW'(sym);
    endfunction

endpackage

FILE: design/nfa_ss_store.sv
// Transition store: one write port, one registered read port.
module nfa_ss_store
    import nfa_ss_pkg::*;
#(
    parameter int DEPTH = 2064
) (
    input  logic                    aclk,
    input  nfa_ss_store_req_t       req,
    output logic [SET_W-1:0]        rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [SET_W-1:0] mem [DEPTH];
    logic [SET_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/nfa_set_step_core.sv
// Top level: NFA move plus epsilon closure over a cleared transition store.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------
//  input    | s_valid / s_ready        | s_data  (nfa_ss_in_t)
//  result   | m_valid / m_ready        | m_data  (nfa_ss_out_t)
//  config   | cfg_wr_en                | cfg_wr_data (final_mask)
//
// An evaluate reads one store row a cycle, move rows first, then one epsilon row per
// closure state, plus a bubble whenever the worklist drains while a row read is still
// in flight.
// After reset the store is swept to empty sets, one entry a cycle, over all
// min(STATE_COUNT,16) * 129 entries (2064 by default) with s_ready low; a stalled m_ready
// holds the block in its last step until the result register frees up.
module nfa_set_step_core
    import nfa_ss_pkg::*;
#(
    parameter int STATE_COUNT = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nfa_ss_in_t        s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output nfa_ss_out_t       m_data,
    input  logic              cfg_wr_en,
    input  logic [SET_W-1:0]  cfg_wr_data
);

    // Only rows reachable through the 4-bit from_state field are stored.
    localparam int ROWS  = (STATE_COUNT < SET_W) ? STATE_COUNT : SET_W;
    localparam int DEPTH = ROWS * SYMBOL_COUNT;
    localparam logic [SET_W-1:0] SET_MASK = {SET_W{1'b1}} >> (SET_W - ROWS);
    localparam logic [STORE_AW-1:0] LAST_ADDR = STORE_AW'(DEPTH - 1);

    nfa_ss_state_t      state_reg, state_next;
    logic [STORE_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [SET_W-1:0]   pend_reg, pend_next;
    logic [SET_W-1:0]   acc_reg, acc_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic               inflight_reg, inflight_next;
    logic               m_valid_reg, m_valid_next;
    nfa_ss_out_t        out_reg, out_next;
    logic [SET_W-1:0]   final_reg;

    nfa_ss_store_req_t  req;
    logic [SET_W-1:0]   rdata;
    logic [SET_W-1:0]   data;
    logic [SET_W-1:0]   pop_hot;
    logic [ROW_W-1:0]   pop_idx;
    logic               accept;

    nfa_ss_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .aclk  (aclk),
        .req   (req),
        .rdata (rdata)
    );

    // Lowest pending state is served next.
    assign pop_hot = pend_reg & (~pend_reg + 1'b1);

    always_comb begin
        pop_idx = '0;
        for (int i = SET_W - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                pop_idx = ROW_W'(i);
            end
        end
    end

    assign data    = inflight_reg ? rdata : '0;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            inflight_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            final_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            inflight_reg <= inflight_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                final_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        acc_reg  <= acc_next;
        sym_reg  <= sym_next;
        out_reg  <= out_next;
    end

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        pend_next     = pend_reg;
        acc_next      = acc_reg;
        sym_next      = sym_reg;
        inflight_next = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        out_next      = out_reg;
        req           = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                req.we       = 1'b1;
                req.waddr    = clr_cnt_reg;
                req.wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.kind == KIND_LOAD) begin
                        req.we    = (s_data.symbol <= EPS_SYMBOL) &&
                                    (32'(s_data.from_state) < ROWS);
                        req.waddr = store_addr(s_data.from_state, s_data.symbol);
                        req.wdata = s_data.target_set & SET_MASK;
                    end else begin
                        acc_next = '0;
                        sym_next = s_data.symbol;
                        if (s_data.symbol > EPS_SYMBOL) begin
                            pend_next  = '0;
                            state_next = ST_DONE;
                        end else begin
                            pend_next  = s_data.state_set & SET_MASK;
                            state_next = ST_MOVE;
                        end
                    end
                end
            end
            ST_MOVE: begin
                req.re        = |pend_reg;
                req.raddr     = store_addr(pop_idx, sym_reg);
                inflight_next = |pend_reg;
                acc_next      = acc_reg | data;
                pend_next     = pend_reg & ~pop_hot;
                if (pend_reg == '0 && !inflight_reg) begin
                    // Move complete: seed the closure worklist with it.
                    pend_next  = acc_reg;
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                req.re        = |pend_reg;
                req.raddr     = store_addr(pop_idx, EPS_SYMBOL);
                inflight_next = |pend_reg;
                acc_next      = acc_reg | data;
                pend_next     = (pend_reg & ~pop_hot) | (data & ~acc_reg);
                if (pend_reg == '0 && !inflight_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.next_set  = acc_reg;
                    out_next.accepting = |(acc_reg & final_reg & SET_MASK);
                    m_valid_next       = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    a_inflight_from_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg |-> ($past(state_reg) == ST_MOVE || $past(state_reg) == ST_CLOSE))
        else $error("store read in flight outside move or closure");

    a_pend_in_closure: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLOSE |-> (pend_reg & ~acc_reg) == '0)
        else $error("closure worklist holds a state outside the closure");

    a_result_masked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.next_set & ~SET_MASK) == '0)
        else $error("result holds a state beyond the state count");

    a_write_when_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        req.we |-> (state_reg == ST_CLEAR || state_reg == ST_IDLE))
        else $error("store write during an evaluate");
`endif

endmodule
